@@ sv/grt_pkg.sv @@
// ============================================================================
// grt_pkg
// Shared types and constants for the grid ray first-solid-tile block.
// ============================================================================
package grt_pkg;

    localparam int MAX_DIM_DEF   = 64;
    localparam int FRAC_BITS_DEF = 8;

    // result status codes
    localparam logic [1:0] ST_WRITE = 2'd0;
    localparam logic [1:0] ST_HIT   = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    // item kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    // register select, paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [6:0] WIDTH_RST  = 7'd6;
    localparam logic [6:0] HEIGHT_RST = 7'd5;

    typedef struct packed {
        logic load;        // capture cast item
        logic wr;          // store write
        logic prep;        // axis select and products
        logic num;         // numerator sum
        logic div_start;
        logic fix;         // floor correction, walk init
        logic step;        // read current tile, advance
        logic commit;      // load output fields
        logic commit_hit;
    } t_cmd;

    typedef struct packed {
        logic zero_dir;
        logic div_done;
        logic prev_hit;
        logic cur_out;
    } t_sts;

endpackage

@@ sv/grt_ram.sv @@
// ============================================================================
// grt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module grt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/grt_div.sv @@
// ============================================================================
// grt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module grt_div #(
    parameter int NW = 30,
    parameter int DW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  r_quo;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DW:0]    trial;
    logic           ge;

    assign trial = {r_rem, r_quo[NW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

@@ sv/grt_dp.sv @@
// ============================================================================
// grt_dp
// Cast datapath: axis select, start numerator, floor divide, DDA walk
// over the tile store, output fields.
// ============================================================================
module grt_dp #(
    parameter int MAX_DIM   = 64,
    parameter int FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grt_pkg::t_cmd     i_cmd,
    output grt_pkg::t_sts     o_sts,
    input  logic [6:0]        i_map_width,
    input  logic [6:0]        i_map_height,
    input  logic [5:0]        i_tile_col,
    input  logic [5:0]        i_tile_row,
    input  logic [7:0]        i_tile_id,
    input  logic [13:0]       i_start_x,
    input  logic [13:0]       i_start_y,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    output logic [5:0]        o_hit_col,
    output logic [5:0]        o_hit_row,
    output logic [7:0]        o_hit_id
);
    import grt_pkg::*;

    localparam int CW   = 16;                     // walk coordinates, signed
    localparam int DW   = 16 + FRAC_BITS;         // divisor |dmaj| << FRAC
    localparam int RW   = DW + 2;                 // running remainder, signed
    localparam int DF   = FRAC_BITS + 2;          // first-step offset, signed
    localparam int P2W  = DF + 17;
    localparam int NW   = (P2W + 1 > 31) ? P2W + 1 : 31;
    localparam int NM   = NW - 1;
    localparam int IW   = $clog2(MAX_DIM);
    localparam int AW   = $clog2(MAX_DIM * MAX_DIM);
    localparam int LW   = $clog2(MAX_DIM + 1);
    localparam logic [DF-1:0] ONE = DF'(1 << FRAC_BITS);

    // ---- captured item
    logic [13:0]        r_sx, r_sy;
    logic signed [15:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx <= i_start_x;
            r_sy <= i_start_y;
            r_dx <= i_dir_x;
            r_dy <= i_dir_y;
        end
    end

    // ---- axis select
    logic [15:0]           ax, ay, amaj;
    logic                  rows, pos;
    logic [13:0]           maj0, min0;
    logic signed [15:0]    dmaj, dmin;
    logic signed [16:0]    dmin_s;
    logic signed [DF-1:0]  diff;
    logic [FRAC_BITS-1:0]  frac;
    logic [LW-1:0]         lim_w, lim_h;

    assign ax     = r_dx[15] ? 16'(-17'(r_dx)) : 16'(r_dx);
    assign ay     = r_dy[15] ? 16'(-17'(r_dy)) : 16'(r_dy);
    assign rows   = ay >= ax;
    assign maj0   = rows ? r_sy : r_sx;
    assign min0   = rows ? r_sx : r_sy;
    assign dmaj   = rows ? r_dy : r_dx;
    assign dmin   = rows ? r_dx : r_dy;
    assign amaj   = rows ? ay : ax;
    assign pos    = !dmaj[15];
    assign dmin_s = pos ? 17'(dmin) : -17'(dmin);
    assign frac   = maj0[FRAC_BITS-1:0];
    assign diff   = pos ? $signed(ONE - DF'(frac)) : -$signed(DF'(frac));

    assign lim_w = (LW'(i_map_width)  > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(i_map_width);
    assign lim_h = (LW'(i_map_height) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(i_map_height);

    logic                  r_rows, r_pos;
    logic [29:0]           r_p1;
    logic signed [P2W-1:0] r_p2;
    logic [DW-1:0]         r_den;
    logic signed [RW-1:0]  r_inc;
    logic [LW-1:0]         r_majlim, r_minlim;
    logic signed [NW-1:0]  r_n0;
    logic                  r_neg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rows   <= rows;
            r_pos    <= pos;
            r_p1     <= 30'(min0) * 30'(amaj);
            r_p2     <= P2W'(diff) * P2W'(dmin_s);
            r_den    <= DW'(amaj) << FRAC_BITS;
            r_inc    <= RW'(dmin) <<< FRAC_BITS;
            r_majlim <= rows ? lim_h : lim_w;
            r_minlim <= rows ? lim_w : lim_h;
        end
        if (i_cmd.num) begin
            r_n0 <= $signed(NW'(r_p1)) + NW'(r_p2);
        end
        if (i_cmd.div_start) begin
            r_neg <= r_n0[NW-1];
        end
    end

    // ---- floor divide
    logic [NM-1:0] div_num;
    logic [NM-1:0] quo;
    logic [DW-1:0] rem;
    logic          div_done;

    assign div_num = r_n0[NW-1] ? NM'(-r_n0) : NM'(r_n0);

    grt_div #(.NW(NM), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    // ---- walk
    logic signed [CW-1:0] r_m, r_k;
    logic signed [RW-1:0] r_rem;
    logic                 r_rdv;
    logic [IW-1:0]        r_pcol, r_prow;
    logic signed [CW-1:0] qs, m0;
    logic signed [CW-1:0] cur_col, cur_row;
    logic signed [RW-1:0] t, den_s;
    logic                 cur_out;
    logic [7:0]           rd_data;
    logic [AW-1:0]        raddr, waddr;
    logic                 wr_ok;

    assign qs      = $signed({1'b0, quo[CW-2:0]});
    assign m0      = $signed(CW'(maj0 >> FRAC_BITS)) + CW'(pos);
    assign den_s   = $signed(RW'(r_den));
    assign t       = r_rem + r_inc;
    assign cur_col = r_rows ? r_k : r_m;
    assign cur_row = r_rows ? r_m : r_k;
    assign cur_out = (r_m < 0) || (r_m >= $signed(CW'(r_majlim)))
                  || (r_k < 0) || (r_k >= $signed(CW'(r_minlim)));
    assign raddr   = AW'(cur_row[IW-1:0]) * AW'(MAX_DIM) + AW'(cur_col[IW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_m <= m0;
        end
        if (i_cmd.fix) begin
            r_rdv <= 1'b0;
            if (r_neg) begin
                r_k   <= (rem != '0) ? -qs - CW'(1) : -qs;
                r_rem <= (rem != '0) ? den_s - RW'(rem) : '0;
            end else begin
                r_k   <= qs;
                r_rem <= RW'(rem);
            end
        end else if (i_cmd.step) begin
            r_rdv  <= 1'b1;
            r_pcol <= cur_col[IW-1:0];
            r_prow <= cur_row[IW-1:0];
            r_m    <= r_pos ? r_m + CW'(1) : r_m - CW'(1);
            if (t >= den_s) begin
                r_rem <= t - den_s;
                r_k   <= r_k + CW'(1);
            end else if (t < 0) begin
                r_rem <= t + den_s;
                r_k   <= r_k - CW'(1);
            end else begin
                r_rem <= t;
            end
        end
    end

    // ---- tile store
    assign wr_ok = (32'(i_tile_col) < MAX_DIM) && (32'(i_tile_row) < MAX_DIM);
    assign waddr = AW'(i_tile_row) * AW'(MAX_DIM) + AW'(i_tile_col);

    grt_ram #(.WIDTH(8), .DEPTH(MAX_DIM * MAX_DIM)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr && wr_ok),
        .i_waddr (waddr),
        .i_wdata (i_tile_id),
        .i_re    (i_cmd.step),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // ---- output fields
    logic [5:0] r_ocol, r_orow;
    logic [7:0] r_oid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ocol <= i_cmd.commit_hit ? 6'(r_pcol) : '0;
            r_orow <= i_cmd.commit_hit ? 6'(r_prow) : '0;
            r_oid  <= i_cmd.commit_hit ? rd_data : '0;
        end
    end

    assign o_hit_col = r_ocol;
    assign o_hit_row = r_orow;
    assign o_hit_id  = r_oid;

    assign o_sts.zero_dir = (r_dx == '0) && (r_dy == '0);
    assign o_sts.div_done = div_done;
    assign o_sts.prev_hit = r_rdv && (rd_data != '0);
    assign o_sts.cur_out  = cur_out;
endmodule

@@ sv/grt_ctrl.sv @@
// ============================================================================
// grt_ctrl
// Sequencer for writes and casts; owns the result valid and status.
// ============================================================================
module grt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output logic [1:0]    o_status,
    input  logic          i_out_ready,
    output grt_pkg::t_cmd o_cmd,
    input  grt_pkg::t_sts i_sts
);
    import grt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_NUM, S_DSTART, S_DWAIT, S_FIX, S_WALK, S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_fin, n_fin;
    logic       r_ovld, n_ovld;
    logic [1:0] r_ostat, n_ostat;
    logic       accept, out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovld || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_ovld  = r_ovld && !i_out_ready;
        n_ostat = r_ostat;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.wr = 1'b1;
                        n_fin    = ST_WRITE;
                        n_state  = S_FIN;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.zero_dir) begin
                    n_fin   = ST_ZERO;
                    n_state = S_FIN;
                end else begin
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_state   = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_WALK;
            end
            S_WALK: begin
                // the tile read last cycle wins over the bounds of the next one
                if (i_sts.prev_hit) begin
                    n_fin   = ST_HIT;
                    n_state = S_FIN;
                end else if (i_sts.cur_out) begin
                    n_fin   = ST_MISS;
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.commit     = 1'b1;
                    o_cmd.commit_hit = (r_fin == ST_HIT);
                    n_ovld           = 1'b1;
                    n_ostat          = r_fin;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin   <= ST_WRITE;
            r_ovld  <= 1'b0;
            r_ostat <= ST_WRITE;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_ovld  <= n_ovld;
            r_ostat <= n_ostat;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_status    = r_ostat;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> r_state == S_DWAIT)
        else $error("divider done outside wait");

    a_walk_nonzero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> !i_sts.zero_dir)
        else $error("walk with zero direction");

    a_fin_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_state == S_IDLE && r_ovld))
        else $error("finished result not posted");

    a_hit_has_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.prev_hit) |=> r_fin == ST_HIT)
        else $error("hit not recorded");
endmodule

@@ sv/grid_ray_first_solid_tile.sv @@
// ============================================================================
// grid_ray_first_solid_tile
// Tile map store with a major-axis grid ray cast to the first solid tile.
// ============================================================================
// Input stream (s_*): one item per handshake. s_tuser selects the kind:
//   0 stores tile_id at (tile_col, tile_row), 1 casts a ray from
//   (start_x, start_y) along (dir_x, dir_y).
// Output stream (m_*): exactly one result item per input item, in order.
//   m_tuser carries the status (write done, hit, miss, zero direction).
// Config (APB): map_width at 0x0, map_height at 0x4, written while idle.
// Sequence: a write goes straight to the finish state, a zero direction
//   via the prep state. Any other cast runs prep, numerator, divider
//   start, the one-bit-per-cycle floor divider and the fix, then walks
//   the visited tiles with one store read each before it finishes.
// One item is worked on at a time; s_tready is high only between items,
//   so the next item can be taken at the earliest in the cycle after the previous result is set.
// A finished result sits in the output register; a new item is accepted
//   while it waits, and the next result holds in the sequencer until the
//   receiver takes the old one.
// Reset clears control and loads the map size registers with 6 and 5; the
//   tile store has no reset, so tiles must be written before a cast reads them.
// ============================================================================
module grid_ray_first_solid_tile #(
    parameter int MAX_DIM   = grt_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = grt_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tile_col[5:0], tile_row[11:6], tile_id[19:12], start_x[33:20],
    // start_y[47:34], dir_x[63:48], dir_y[79:64]
    input  logic [79:0] s_tdata,
    // action[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hit_col[5:0], hit_row[11:6], hit_id[19:12], zero[23:20]
    output logic [23:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import grt_pkg::*;

    // map size registers
    logic [6:0] r_map_width, r_map_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= WIDTH_RST;
            r_map_height <= HEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_WIDTH:  r_map_width  <= pwdata[6:0];
                REG_HEIGHT: r_map_height <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(r_map_height) : 32'(r_map_width);

    t_cmd       cmd;
    t_sts       sts;
    logic [5:0] hit_col, hit_row;
    logic [7:0] hit_id;

    grt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .i_action    (s_tuser),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .o_status    (m_tuser),
        .i_out_ready (m_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    grt_dp #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_map_width  (r_map_width),
        .i_map_height (r_map_height),
        .i_tile_col   (s_tdata[5:0]),
        .i_tile_row   (s_tdata[11:6]),
        .i_tile_id    (s_tdata[19:12]),
        .i_start_x    (s_tdata[33:20]),
        .i_start_y    (s_tdata[47:34]),
        .i_dir_x      (s_tdata[63:48]),
        .i_dir_y      (s_tdata[79:64]),
        .o_hit_col    (hit_col),
        .o_hit_row    (hit_row),
        .o_hit_id     (hit_id)
    );

    assign m_tdata = {4'b0, hit_id, hit_row, hit_col};
endmodule
